/* rtl/ufr_pkg.sv */
// Shared types, constants and helper functions for the UDP/IPv4/Ethernet framer.
`timescale 1ns / 1ps

package ufr_pkg;

  // Header geometry
  localparam int HDR_BYTES = 42;
  localparam int HDR_IDX_W = 6;

  // Queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  // IPv4 header checksum: ten 16-bit words summed with room for carries
  localparam int CK_WORDS  = 10;
  localparam int CK_IDX_W  = 4;
  localparam int CK_ACC_W  = 20;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEST_MAC   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_MAC = 2'd1;

  // Fixed header fields
  localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  IP_VER_IHL    = 8'h45;
  localparam logic [7:0]  IP_FLAGS_DF   = 8'h40;
  localparam logic [7:0]  IP_TTL        = 8'h33;
  localparam logic [7:0]  IP_PROTO_UDP  = 8'h11;
  localparam logic [15:0] IP_UDP_HDR_LEN = 16'd28;
  localparam logic [15:0] UDP_HDR_LEN    = 16'd8;

  // One classified word as it waits between front and back
  typedef struct packed {
    logic        is_hdr;   // packet start: header goes out first
    logic        has_pay;  // packet start carries a payload byte
    logic        last;     // payload byte closes the frame
    logic [7:0]  pbyte;
    logic [15:0] ip_len;
    logic [15:0] udp_len;
    logic [31:0] sip;
    logic [31:0] dip;
    logic [15:0] sport;
    logic [15:0] dport;
  } ufr_entry_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } ufr_q_status_t;

  // Return IPv4 header word number idx, checksum word taken as zero
  function automatic logic [15:0] ufr_ck_word(input logic [CK_IDX_W-1:0] idx,
                                              input logic [15:0] ip_len,
                                              input logic [31:0] sip,
                                              input logic [31:0] dip);
    logic [15:0] w;
    begin
      case (idx)
        4'd0:    w = {IP_VER_IHL, 8'h00};
        4'd1:    w = ip_len;
        4'd2:    w = 16'h0000;
        4'd3:    w = {IP_FLAGS_DF, 8'h00};
        4'd4:    w = {IP_TTL, IP_PROTO_UDP};
        4'd5:    w = 16'h0000;
        4'd6:    w = sip[31:16];
        4'd7:    w = sip[15:0];
        4'd8:    w = dip[31:16];
        4'd9:    w = dip[15:0];
        default: w = 16'h0000;
      endcase
      return w;
    end
  endfunction

endpackage

/* rtl/udp_ipv4_ethernet_framer.sv */
// Top level of the UDP/IPv4/Ethernet framer: config registers, front, queue and back.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+----------------------------------------
//  in      | input     | in_valid_i / in_stall_o   | payload_byte, payload_length, ips, ports
//  out     | output    | out_valid_o / out_stall_i | frame_byte, frame_last
//  cfg     | input     | cfg_we_i (no wait)        | cfg_index_i, cfg_wdata_i
//
// Payload words pass at one word per cycle while the output is not stalled. A packet start
// word loads the back-end header sequencer, then emits 42 header bytes plus any payload byte.
// A four-word queue decouples input from output; input stalls only when it is full.
// Reset is asynchronous, active low; no clearing pass is needed after it.
// An output stall holds the output register while the front keeps filling the queue.
`timescale 1ns / 1ps

module udp_ipv4_ethernet_framer
  import ufr_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [47:0]          cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [7:0]           payload_byte_i,
  input  logic [15:0]          payload_length_i,
  input  logic [31:0]          source_ip_i,
  input  logic [31:0]          dest_ip_i,
  input  logic [15:0]          source_port_i,
  input  logic [15:0]          dest_port_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [7:0]           frame_byte_o,
  output logic                 frame_last_o
);

  logic [47:0]   dest_mac_q, source_mac_q;
  ufr_q_status_t q_status;
  ufr_entry_t    push_entry, head_entry;
  logic          push, pop;

  // Write MAC registers; other indexes drop
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dest_mac_q   <= 48'd0;
      source_mac_q <= 48'd0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_DEST_MAC:   dest_mac_q   <= cfg_wdata_i;
        CFG_SOURCE_MAC: source_mac_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  ufr_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .payload_byte_i   (payload_byte_i),
    .payload_length_i (payload_length_i),
    .source_ip_i      (source_ip_i),
    .dest_ip_i        (dest_ip_i),
    .source_port_i    (source_port_i),
    .dest_port_i      (dest_port_i),
    .q_status_i       (q_status),
    .push_o           (push),
    .entry_o          (push_entry)
  );

  ufr_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .entry_i  (push_entry),
    .pop_i    (pop),
    .head_o   (head_entry),
    .status_o (q_status)
  );

  ufr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .dest_mac_i   (dest_mac_q),
    .source_mac_i (source_mac_q),
    .q_status_i   (q_status),
    .head_i       (head_entry),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .frame_byte_o (frame_byte_o),
    .frame_last_o (frame_last_o)
  );

endmodule

/* rtl/ufr_front.sv */
// Front end: accepts input words, tracks packet position and classifies each word.
`timescale 1ns / 1ps

module ufr_front
  import ufr_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [7:0]    payload_byte_i,
  input  logic [15:0]   payload_length_i,
  input  logic [31:0]   source_ip_i,
  input  logic [31:0]   dest_ip_i,
  input  logic [15:0]   source_port_i,
  input  logic [15:0]   dest_port_i,
  input  ufr_q_status_t q_status_i,
  output logic          push_o,
  output ufr_entry_t    entry_o
);

  logic [15:0] remaining_q, remaining_d;
  logic        start;

  assign in_stall_o = q_status_i.full;
  assign push_o     = in_valid_i & ~q_status_i.full;
  assign start      = (remaining_q == 16'd0);

  // Classify the word and compute length fields at packet start
  always_comb begin
    entry_o.is_hdr  = start;
    entry_o.has_pay = (payload_length_i != 16'd0);
    entry_o.last    = start ? (payload_length_i == 16'd1) : (remaining_q == 16'd1);
    entry_o.pbyte   = payload_byte_i;
    entry_o.ip_len  = payload_length_i + IP_UDP_HDR_LEN;
    entry_o.udp_len = payload_length_i + UDP_HDR_LEN;
    entry_o.sip     = source_ip_i;
    entry_o.dip     = dest_ip_i;
    entry_o.sport   = source_port_i;
    entry_o.dport   = dest_port_i;
  end

  // Count down payload bytes still owed to the current packet
  always_comb begin
    remaining_d = remaining_q;
    if (push_o) begin
      if (start) begin
        remaining_d = (payload_length_i == 16'd0) ? 16'd0 : payload_length_i - 16'd1;
      end else begin
        remaining_d = remaining_q - 16'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      remaining_q <= 16'd0;
    end else begin
      remaining_q <= remaining_d;
    end
  end

endmodule

/* rtl/ufr_fifo.sv */
// Short queue of classified words between front and back.
`timescale 1ns / 1ps

module ufr_fifo
  import ufr_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ufr_entry_t    entry_i,
  input  logic          pop_i,
  output ufr_entry_t    head_o,
  output ufr_q_status_t status_o
);

  ufr_entry_t           slots_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [FIFO_AW:0]     count_q;
  logic                 do_push, do_pop;

  assign status_o.full  = (count_q == (FIFO_AW+1)'(FIFO_DEPTH));
  assign status_o.empty = (count_q == '0);
  assign head_o         = slots_q[rd_ptr_q];

  assign do_push = push_i & ~status_o.full;
  assign do_pop  = pop_i & ~status_o.empty;

  // Store payload of pushed words
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= entry_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

/* rtl/ufr_back.sv */
// Back end: sequences header bytes, computes the IPv4 checksum and drives the output register.
`timescale 1ns / 1ps

module ufr_back
  import ufr_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [47:0]   dest_mac_i,
  input  logic [47:0]   source_mac_i,
  input  ufr_q_status_t q_status_i,
  input  ufr_entry_t    head_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [7:0]    frame_byte_o,
  output logic          frame_last_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_HDR  = 3'b010,
    ST_PAY  = 3'b100
  } back_state_e;

  back_state_e             state_q, state_d;
  ufr_entry_t              cur_q, cur_d;
  logic [HDR_IDX_W-1:0]    idx_q, idx_d;
  logic [CK_IDX_W-1:0]     ck_cnt_q, ck_cnt_d;
  logic [CK_ACC_W-1:0]     acc_q, acc_d;
  logic                    out_valid_q, out_valid_d;
  logic [7:0]              out_byte_q, out_byte_d;
  logic                    out_last_q, out_last_d;

  logic                    advance;
  logic                    emit;
  logic [7:0]              emit_byte;
  logic                    emit_last;
  logic [16:0]             fold1;
  logic [15:0]             fold2;
  logic [15:0]             checksum;
  logic [HDR_BYTES*8-1:0]  hdr_vec;
  logic [HDR_IDX_W-1:0]    sel;

  assign advance = ~out_valid_q | ~out_stall_i;

  // Fold carries back in and complement
  assign fold1    = {1'b0, acc_q[15:0]} + {13'd0, acc_q[CK_ACC_W-1:16]};
  assign fold2    = fold1[15:0] + {15'd0, fold1[16]};
  assign checksum = ~fold2;

  // Whole header in transmit order, first byte at the top
  assign hdr_vec = {dest_mac_i, source_mac_i, ETH_TYPE_IPV4,
                    IP_VER_IHL, 8'h00, cur_q.ip_len, 16'h0000,
                    IP_FLAGS_DF, 8'h00, IP_TTL, IP_PROTO_UDP, checksum,
                    cur_q.sip, cur_q.dip, cur_q.sport, cur_q.dport,
                    cur_q.udp_len, 16'h0000};
  assign sel = HDR_IDX_W'(HDR_BYTES - 1) - idx_q;

  // Sequence header, payload and bypass words
  always_comb begin
    state_d   = state_q;
    cur_d     = cur_q;
    idx_d     = idx_q;
    ck_cnt_d  = ck_cnt_q;
    acc_d     = acc_q;
    pop_o     = 1'b0;
    emit      = 1'b0;
    emit_byte = 8'h00;
    emit_last = 1'b0;

    // Accumulate one checksum word per cycle, independent of output stalls
    if (ck_cnt_q != CK_IDX_W'(CK_WORDS)) begin
      acc_d    = acc_q + {4'd0, ufr_ck_word(ck_cnt_q, cur_q.ip_len, cur_q.sip, cur_q.dip)};
      ck_cnt_d = ck_cnt_q + 1'b1;
    end

    case (state_q)
      ST_IDLE: begin
        if (!q_status_i.empty) begin
          if (head_i.is_hdr) begin
            pop_o    = 1'b1;
            cur_d    = head_i;
            idx_d    = '0;
            acc_d    = '0;
            ck_cnt_d = '0;
            state_d  = ST_HDR;
          end else if (advance) begin
            pop_o     = 1'b1;
            emit      = 1'b1;
            emit_byte = head_i.pbyte;
            emit_last = head_i.last;
          end
        end
      end
      ST_HDR: begin
        if (advance) begin
          emit      = 1'b1;
          emit_byte = hdr_vec[{sel, 3'b000} +: 8];
          if (idx_q == HDR_IDX_W'(HDR_BYTES - 1)) begin
            emit_last = ~cur_q.has_pay;
            idx_d     = '0;
            state_d   = cur_q.has_pay ? ST_PAY : ST_IDLE;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      ST_PAY: begin
        if (advance) begin
          emit      = 1'b1;
          emit_byte = cur_q.pbyte;
          emit_last = cur_q.last;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Load output register when the consumer can take a word
  always_comb begin
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    if (advance) begin
      out_valid_d = emit;
      out_byte_d  = emit_byte;
      out_last_d  = emit_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      ck_cnt_q    <= CK_IDX_W'(CK_WORDS);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      ck_cnt_q    <= ck_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    acc_q      <= acc_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o  = out_valid_q;
  assign frame_byte_o = out_byte_q;
  assign frame_last_o = out_last_q;

endmodule

/* rtl/ufr_checker.sv */
// Port-level checker for the framer, bound to the top level.
`timescale 1ns / 1ps

module ufr_checker
  import ufr_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic [7:0]           frame_byte_o,
  input logic                 frame_last_o
);

  logic                 out_acc;
  logic [HDR_IDX_W-1:0] pos_q;

  assign out_acc = out_valid_o & ~out_stall_i;

  // Track the position of each word within its frame, saturating
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (out_acc) begin
      if (frame_last_o) begin
        pos_q <= '0;
      end else if (pos_q != '1) begin
        pos_q <= pos_q + 1'b1;
      end
    end
  end

  // A stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(frame_byte_o) && $stable(frame_last_o))
    else $error("stalled output word changed");

  // A frame is never shorter than its header
  a_min_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && frame_last_o |-> pos_q >= HDR_IDX_W'(HDR_BYTES - 1))
    else $error("frame ended inside the header");

  // EtherType high byte sits after the two MAC addresses
  a_eth_type: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && pos_q == HDR_IDX_W'(12) |-> frame_byte_o == ETH_TYPE_IPV4[15:8])
    else $error("EtherType byte wrong");

  // IPv4 version and header length open the IP header
  a_ver_ihl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && pos_q == HDR_IDX_W'(14) |-> frame_byte_o == IP_VER_IHL)
    else $error("IPv4 version/IHL byte wrong");

endmodule

bind udp_ipv4_ethernet_framer ufr_checker u_ufr_checker (.*);
